[hdl/pdlz_pkg.sv]
// ----------------------------------------------------------------------------
// pdlz_pkg
// Shared constants and types of the PalmDoc LZ77 record decoder.
// ----------------------------------------------------------------------------
package pdlz_pkg;

    localparam int HISTORY_DEPTH = 2048;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    localparam logic [7:0]  RAW_MIN     = 8'h01;
    localparam logic [7:0]  RAW_MAX     = 8'h08;
    localparam logic [7:0]  LIT_MAX     = 8'h7f;
    localparam logic [7:0]  SPACE_MIN   = 8'hc0;
    localparam logic [7:0]  SPACE_CHAR  = 8'h20;
    localparam logic [7:0]  LOW7_MASK   = 8'h7f;
    localparam logic [3:0]  LEN_BASE    = 4'd3;
    localparam logic [15:0] LIMIT_RESET = 16'd4096;

    typedef struct packed {
        logic               ok;
        logic [3:0]         len;
        logic [HIST_AW-1:0] src;
    } t_ref_info;

endpackage

[hdl/palmdoc_lz77_decoder.sv]
// ----------------------------------------------------------------------------
// palmdoc_lz77_decoder
// PalmDoc LZ77 record decoder: one compressed byte in, decoded bytes out.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_stall) carries one compressed byte and a
// record end flag per transfer. The output channel (o_valid, i_stall) carries
// one result per transfer: a decoded byte or, at a record end that yields no
// byte, an empty result with the record length.
// Literals, raw bytes and the space of a space pair are emitted as their
// input is taken; the second byte of a space pair follows from S_SECOND. A
// back-reference first reads the history and then copies its 3 to 10 bytes
// in S_COPY, one read of the single history read port per copied byte.
// Each result is registered in the output register; the first byte of a
// back-reference is read into the history read register before that.
// The input is stalled while a multi-byte sequence runs or while the output
// register holds a result that the receiver stalls. A stalled result holds.
// The output limit is written through i_cfg_we and i_cfg_data and resets to
// 4096. Reset clears the record state; the history needs no clearing, since
// a reference only reads bytes written earlier in the same record.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_code_byte,
    input  logic        i_record_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_run_last,
    output logic        o_record_done,
    output logic        o_bad_reference,
    output logic [15:0] o_decoded_length
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_SECOND
    } t_state;

    t_state                      r_state, n_state;
    logic [15:0]                 r_limit;
    logic [15:0]                 r_cnt, n_cnt;
    logic [3:0]                  r_raw, n_raw;
    logic                        r_pend, n_pend;
    logic [7:0]                  r_high, n_high;
    logic                        r_stop, n_stop;
    logic [3:0]                  r_len, n_len;
    logic                        r_last, n_last;
    logic [7:0]                  r_sec, n_sec;
    logic [pdlz_pkg::HIST_AW-1:0] r_src, n_src;

    logic                        r_o_valid;
    logic [7:0]                  r_out_byte, n_out_byte;
    logic                        r_byte_valid, n_byte_valid;
    logic                        r_run_last, n_run_last;
    logic                        r_record_done, n_record_done;
    logic                        r_bad_ref, n_bad_ref;
    logic [15:0]                 r_dec_len, n_dec_len;

    logic                        out_free;
    logic                        acc;
    logic                        room;
    logic                        emit;
    logic                        fin;
    logic                        empty;
    logic                        rec_last;
    logic [7:0]                  byte_val;
    logic                        wr_en;
    logic [7:0]                  rd_data;
    pdlz_pkg::t_ref_info         ref_info;

    pdlz_ref_check u_ref_check (
        .i_pair_high (r_high),
        .i_pair_low  (i_code_byte),
        .i_count     (r_cnt),
        .i_limit     (r_limit),
        .o_info      (ref_info)
    );

    pdlz_history u_history (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cnt[pdlz_pkg::HIST_AW-1:0]),
        .i_wdata (byte_val),
        .i_raddr (n_src),
        .o_rdata (rd_data)
    );

    always_comb begin
        out_free = !r_o_valid || !i_stall;
        acc      = i_valid && out_free && (r_state == S_IDLE);
        room     = r_cnt < r_limit;

        n_state  = r_state;
        n_cnt    = r_cnt;
        n_raw    = r_raw;
        n_pend   = r_pend;
        n_high   = r_high;
        n_stop   = r_stop;
        n_len    = r_len;
        n_last   = r_last;
        n_sec    = r_sec;
        n_src    = r_src;
        emit     = 1'b0;
        fin      = 1'b0;
        empty    = 1'b0;
        rec_last = r_last;
        byte_val = 8'h00;

        case (r_state)
            S_IDLE: begin
                rec_last = i_record_end;
                if (acc) begin
                    if (r_stop || !room) begin
                        empty = i_record_end;
                    end else if (r_raw != 4'd0) begin
                        n_raw    = r_raw - 4'd1;
                        emit     = 1'b1;
                        fin      = 1'b1;
                        byte_val = i_code_byte;
                    end else if (r_pend) begin
                        n_pend = 1'b0;
                        n_high = 8'h00;
                        if (!ref_info.ok) begin
                            n_stop = 1'b1;
                            empty  = i_record_end;
                        end else begin
                            n_len   = ref_info.len;
                            n_src   = ref_info.src;
                            n_last  = i_record_end;
                            n_state = S_COPY;
                        end
                    end else if ((i_code_byte >= pdlz_pkg::RAW_MIN)
                                 && (i_code_byte <= pdlz_pkg::RAW_MAX)) begin
                        n_raw = i_code_byte[3:0];
                        empty = i_record_end;
                    end else if (i_code_byte <= pdlz_pkg::LIT_MAX) begin
                        emit     = 1'b1;
                        fin      = 1'b1;
                        byte_val = i_code_byte;
                    end else if (i_code_byte >= pdlz_pkg::SPACE_MIN) begin
                        emit     = 1'b1;
                        byte_val = pdlz_pkg::SPACE_CHAR;
                        if ((r_cnt + 16'd1) < r_limit) begin
                            n_sec   = i_code_byte & pdlz_pkg::LOW7_MASK;
                            n_last  = i_record_end;
                            n_state = S_SECOND;
                        end else begin
                            fin = 1'b1;
                        end
                    end else if (!i_record_end) begin
                        n_pend = 1'b1;
                        n_high = i_code_byte;
                    end else begin
                        empty = 1'b1;
                    end
                end
            end
            S_COPY: begin
                if (out_free) begin
                    emit     = 1'b1;
                    byte_val = rd_data;
                    fin      = (r_len == 4'd1);
                    n_len    = r_len - 4'd1;
                    n_src    = r_src + pdlz_pkg::HIST_AW'(1);
                    if (r_len == 4'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SECOND: begin
                if (out_free) begin
                    emit     = 1'b1;
                    fin      = 1'b1;
                    byte_val = r_sec;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        wr_en = emit;
        if (emit) begin
            n_cnt = r_cnt + 16'd1;
        end

        n_out_byte    = emit ? byte_val : 8'h00;
        n_byte_valid  = emit;
        n_run_last    = empty || fin;
        n_record_done = (empty || fin) && rec_last;
        n_bad_ref     = n_stop;
        n_dec_len     = n_record_done ? n_cnt : 16'd0;

        if (n_record_done) begin
            n_cnt  = 16'd0;
            n_raw  = 4'd0;
            n_pend = 1'b0;
            n_high = 8'h00;
            n_stop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= pdlz_pkg::LIMIT_RESET;
            r_cnt     <= 16'd0;
            r_raw     <= 4'd0;
            r_pend    <= 1'b0;
            r_high    <= 8'h00;
            r_stop    <= 1'b0;
            r_len     <= 4'd0;
            r_last    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_raw   <= n_raw;
            r_pend  <= n_pend;
            r_high  <= n_high;
            r_stop  <= n_stop;
            r_len   <= n_len;
            r_last  <= n_last;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (emit || empty) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        r_sec <= n_sec;
        r_src <= n_src;
        if (emit || empty) begin
            r_out_byte    <= n_out_byte;
            r_byte_valid  <= n_byte_valid;
            r_run_last    <= n_run_last;
            r_record_done <= n_record_done;
            r_bad_ref     <= n_bad_ref;
            r_dec_len     <= n_dec_len;
        end
    end

    assign o_stall          = !((r_state == S_IDLE) && (!r_o_valid || !i_stall));
    assign o_valid          = r_o_valid;
    assign o_out_byte       = r_out_byte;
    assign o_byte_valid     = r_byte_valid;
    assign o_run_last       = r_run_last;
    assign o_record_done    = r_record_done;
    assign o_bad_reference  = r_bad_ref;
    assign o_decoded_length = r_dec_len;

`ifndef ASSERT_OFF
    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_len != 4'd0))
        else $error("copy running with no bytes left");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_record_done) |-> r_run_last)
        else $error("record done on a result that is not the last of its input");

    a_empty_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_byte_valid) |-> r_record_done)
        else $error("empty result outside a record end");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_record_done)
        |-> ((r_cnt == 16'd0) && !r_stop && !r_pend && (r_raw == 4'd0)))
        else $error("record state not cleared at record end");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken during a multi-byte sequence");
`endif

endmodule

[hdl/pdlz_history.sv]
// ----------------------------------------------------------------------------
// pdlz_history
// History buffer of decoded bytes with a registered read port. A read of the
// address written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module pdlz_history (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [pdlz_pkg::HIST_AW-1:0] i_waddr,
    input  logic [7:0]                  i_wdata,
    input  logic [pdlz_pkg::HIST_AW-1:0] i_raddr,
    output logic [7:0]                  o_rdata
);

    logic [7:0] r_mem [pdlz_pkg::HISTORY_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/pdlz_ref_check.sv]
// ----------------------------------------------------------------------------
// pdlz_ref_check
// Decodes a back-reference pair into length and source address and checks
// it against the bytes written so far and the record limit.
// ----------------------------------------------------------------------------
module pdlz_ref_check (
    input  logic [7:0]           i_pair_high,
    input  logic [7:0]           i_pair_low,
    input  logic [15:0]          i_count,
    input  logic [15:0]          i_limit,
    output pdlz_pkg::t_ref_info  o_info
);

    logic [10:0] back_dist;
    logic [3:0]  len;
    logic [16:0] end_pos;

    always_comb begin
        back_dist = {i_pair_high[5:0], i_pair_low[7:3]};
        len       = pdlz_pkg::LEN_BASE + {1'b0, i_pair_low[2:0]};
        end_pos   = {1'b0, i_count} + {13'd0, len};
        o_info.len = len;
        o_info.src = i_count[pdlz_pkg::HIST_AW-1:0] - pdlz_pkg::HIST_AW'(back_dist);
        o_info.ok  = (back_dist != 11'd0) && ({5'd0, back_dist} <= i_count)
                     && (end_pos <= {1'b0, i_limit});
    end

endmodule
